/* design/tnus_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and rounding helper for the triangle normal/uv setup block
// used by tnus_regs, tnus_ctrl, tnus_dp and the top level
package tnus_pkg;

   localparam int CoordW  = 24;
   localparam int DiffW   = 25;
   localparam int CrossW  = 52;
   localparam int NormW   = 16;
   localparam int CfgW    = 32;
   localparam int IndexW  = 4;
   localparam int RspW    = 168;

   localparam logic [63:0] ScaleNum = (64'd583667 << 32) + 64'd14400000;
   localparam logic [31:0] SCALE_K  = 32'(ScaleNum / 64'd28800000);

   localparam logic [IndexW-1:0] CSR_U_VEC_X  = 4'd0;
   localparam logic [IndexW-1:0] CSR_U_VEC_Y  = 4'd1;
   localparam logic [IndexW-1:0] CSR_U_VEC_Z  = 4'd2;
   localparam logic [IndexW-1:0] CSR_U_OFFSET = 4'd3;
   localparam logic [IndexW-1:0] CSR_V_VEC_X  = 4'd4;
   localparam logic [IndexW-1:0] CSR_V_VEC_Y  = 4'd5;
   localparam logic [IndexW-1:0] CSR_V_VEC_Z  = 4'd6;
   localparam logic [IndexW-1:0] CSR_V_OFFSET = 4'd7;

   localparam logic [1:0] VSEL_A = 2'd0;
   localparam logic [1:0] VSEL_C = 2'd1;
   localparam logic [1:0] VSEL_B = 2'd2;

   typedef struct packed {
      logic signed [CfgW-1:0] u_x;
      logic signed [CfgW-1:0] u_y;
      logic signed [CfgW-1:0] u_z;
      logic signed [CfgW-1:0] u_off;
      logic signed [CfgW-1:0] v_x;
      logic signed [CfgW-1:0] v_y;
      logic signed [CfgW-1:0] v_z;
      logic signed [CfgW-1:0] v_off;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] z;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] x;
   } vertex_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_STORE_A, OP_STORE_B, OP_STORE_C, OP_MAG_LOAD, OP_MAG_RIGHT,
      OP_MAG_LEFT, OP_SQRT_LOAD, OP_SQRT_STEP, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE
   } op_type;

   typedef enum logic [3:0] {
      A_ZERO, A_D1X, A_D1Y, A_D1Z, A_MAG0, A_MAG1, A_MAG2,
      A_VX, A_VY, A_VZ, A_VNY, A_UOFF, A_VOFF
   } a_sel_type;

   typedef enum logic [3:0] {
      B_ZERO, B_D2X, B_D2Y, B_D2Z, B_MAG0, B_MAG1, B_MAG2, B_K,
      B_UX, B_UY, B_UZ, B_VX, B_VY, B_VZ, B_256
   } b_sel_type;

   typedef enum logic [2:0] {
      MAC_HOLD, MAC_CLR_ADD, MAC_CLR_SUB, MAC_ADD, MAC_SUB
   } mac_type;

   typedef enum logic [3:0] {
      CAP_NONE, CAP_CR0, CAP_CR1, CAP_CR2, CAP_POSX, CAP_POSY, CAP_POSZ, CAP_U, CAP_V
   } cap_type;

   typedef struct packed {
      op_type    op;
      a_sel_type a_sel;
      b_sel_type b_sel;
      mac_type   mac;
      cap_type   cap;
      logic [1:0] vsel;
      logic [1:0] comp;
      logic [4:0] idx;
   } cmd_type;

   typedef struct packed {
      logic degenerate;
      logic mag_high;
      logic mag_low;
   } status_type;

   // round to nearest, ties away from zero, then clamp to 24 bits
   function automatic logic signed [CoordW-1:0] round_sat24(input logic signed [63:0] v,
                                                            input int n);
      logic [63:0] mag;
      logic [63:0] r;
      logic signed [64:0] s;
      mag = v[63] ? 64'(-v) : 64'(v);
      r   = (mag + (64'd1 << (n - 1))) >> n;
      s   = v[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (s > 65'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (s < -65'sd8388608) begin
         return 24'sh800000;
      end
      return s[CoordW-1:0];
   endfunction

endpackage

/* design/tnus_regs.sv */
`timescale 1ns / 1ps
// configuration register file: texture vectors and offsets
// depends on tnus_pkg
module tnus_regs (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [tnus_pkg::IndexW-1:0] wr_index,
   input  logic [tnus_pkg::CfgW-1:0]  wr_data,
   output tnus_pkg::cfg_type          cfg
);
   import tnus_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_U_VEC_X:  cfg_in.u_x   = wr_data;
            CSR_U_VEC_Y:  cfg_in.u_y   = wr_data;
            CSR_U_VEC_Z:  cfg_in.u_z   = wr_data;
            CSR_U_OFFSET: cfg_in.u_off = wr_data;
            CSR_V_VEC_X:  cfg_in.v_x   = wr_data;
            CSR_V_VEC_Y:  cfg_in.v_y   = wr_data;
            CSR_V_VEC_Z:  cfg_in.v_z   = wr_data;
            CSR_V_OFFSET: cfg_in.v_off = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{u_x: 32'sd1048576, v_y: 32'sd1048576, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/tnus_dp.sv */
`timescale 1ns / 1ps
// datapath: vertex store, shared multiply-accumulate, normalise shifter,
// square root and divide units, output registers; depends on tnus_pkg
module tnus_dp (
   input  logic                        clock,
   input  tnus_pkg::cmd_type           cmd,
   input  tnus_pkg::cfg_type           cfg,
   input  logic [71:0]                 in_data,
   output tnus_pkg::status_type        status,
   output logic [tnus_pkg::RspW-1:0]   rsp_data
);
   import tnus_pkg::*;

   vertex_type in_vert;
   vertex_type held_ff [3];
   vertex_type vert;
   logic signed [DiffW-1:0] d1_ff [3];
   logic signed [DiffW-1:0] d2_ff [3];
   logic signed [63:0] prod_ff;
   mac_type mac_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] acc_in;
   logic signed [CrossW-1:0] cr_ff [3];
   logic [CrossW-1:0] mag_ff [3];
   logic [63:0] rad_ff;
   logic [63:0] root_ff;
   logic [44:0] num_ff;
   logic [14:0] quo_ff;
   logic signed [NormW-1:0] nrm_ff [3];
   logic signed [CoordW-1:0] pos_ff [3];
   logic signed [CoordW-1:0] u_ff;
   logic signed [CoordW-1:0] v_ff;
   logic signed [32:0] a_op;
   logic signed [32:0] b_op;
   logic signed [65:0] mul_full;
   logic [63:0] sq_bit;
   logic [63:0] sq_try;
   logic [44:0] div_sub;
   logic [14:0] quo_clip;
   logic signed [NormW-1:0] norm_z;

   assign in_vert = in_data;

   always_comb begin
      case (cmd.vsel)
         VSEL_A:  vert = held_ff[0];
         VSEL_C:  vert = held_ff[2];
         default: vert = held_ff[1];
      endcase
   end

   always_comb begin
      case (cmd.a_sel)
         A_D1X:   a_op = 33'(d1_ff[0]);
         A_D1Y:   a_op = 33'(d1_ff[1]);
         A_D1Z:   a_op = 33'(d1_ff[2]);
         A_MAG0:  a_op = $signed({3'b0, mag_ff[0][29:0]});
         A_MAG1:  a_op = $signed({3'b0, mag_ff[1][29:0]});
         A_MAG2:  a_op = $signed({3'b0, mag_ff[2][29:0]});
         A_VX:    a_op = 33'(vert.x);
         A_VY:    a_op = 33'(vert.y);
         A_VZ:    a_op = 33'(vert.z);
         A_VNY:   a_op = -33'(vert.y);
         A_UOFF:  a_op = 33'(cfg.u_off);
         A_VOFF:  a_op = 33'(cfg.v_off);
         default: a_op = '0;
      endcase
      case (cmd.b_sel)
         B_D2X:   b_op = 33'(d2_ff[0]);
         B_D2Y:   b_op = 33'(d2_ff[1]);
         B_D2Z:   b_op = 33'(d2_ff[2]);
         B_MAG0:  b_op = $signed({3'b0, mag_ff[0][29:0]});
         B_MAG1:  b_op = $signed({3'b0, mag_ff[1][29:0]});
         B_MAG2:  b_op = $signed({3'b0, mag_ff[2][29:0]});
         B_K:     b_op = $signed({1'b0, SCALE_K});
         B_UX:    b_op = 33'(cfg.u_x);
         B_UY:    b_op = 33'(cfg.u_y);
         B_UZ:    b_op = 33'(cfg.u_z);
         B_VX:    b_op = 33'(cfg.v_x);
         B_VY:    b_op = 33'(cfg.v_y);
         B_VZ:    b_op = 33'(cfg.v_z);
         B_256:   b_op = 33'sd256;
         default: b_op = '0;
      endcase
   end

   assign mul_full = a_op * b_op;

   always_comb begin
      case (mac_ff)
         MAC_CLR_ADD: acc_in = prod_ff;
         MAC_CLR_SUB: acc_in = -prod_ff;
         MAC_ADD:     acc_in = acc_ff + prod_ff;
         MAC_SUB:     acc_in = acc_ff - prod_ff;
         default:     acc_in = acc_ff;
      endcase
   end

   assign sq_bit   = 64'd1 << {cmd.idx, 1'b0};
   assign sq_try   = root_ff + sq_bit;
   assign div_sub  = 45'(root_ff[30:0]) << cmd.idx[3:0];
   assign quo_clip = (quo_ff > 15'd16384) ? 15'd16384 : quo_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_full[63:0];
      mac_ff  <= cmd.mac;
      acc_ff  <= acc_in;

      case (cmd.op)
         OP_STORE_A: held_ff[0] <= in_vert;
         OP_STORE_B: held_ff[1] <= in_vert;
         OP_STORE_C: begin
            held_ff[2] <= in_vert;
            d1_ff[0]   <= 25'(in_vert.x) - 25'(held_ff[0].x);
            d1_ff[1]   <= 25'(in_vert.y) - 25'(held_ff[0].y);
            d1_ff[2]   <= 25'(in_vert.z) - 25'(held_ff[0].z);
            d2_ff[0]   <= 25'(held_ff[1].x) - 25'(held_ff[0].x);
            d2_ff[1]   <= 25'(held_ff[1].y) - 25'(held_ff[0].y);
            d2_ff[2]   <= 25'(held_ff[1].z) - 25'(held_ff[0].z);
         end
         OP_MAG_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= cr_ff[i][CrossW-1] ? CrossW'(-cr_ff[i]) : CrossW'(cr_ff[i]);
            end
         end
         OP_MAG_RIGHT: begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
         end
         OP_MAG_LEFT: begin
            for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
         end
         OP_SQRT_LOAD: begin
            rad_ff  <= acc_ff;
            root_ff <= '0;
         end
         OP_SQRT_STEP: begin
            if (rad_ff >= sq_try) begin
               rad_ff  <= rad_ff - sq_try;
               root_ff <= (root_ff >> 1) + sq_bit;
            end else begin
               root_ff <= root_ff >> 1;
            end
         end
         OP_DIV_LOAD: begin
            num_ff <= 45'({mag_ff[cmd.comp][29:0], 14'b0}) + 45'(root_ff[30:1]);
            quo_ff <= '0;
         end
         OP_DIV_STEP: begin
            if (num_ff >= div_sub) begin
               num_ff              <= num_ff - div_sub;
               quo_ff[cmd.idx[3:0]] <= 1'b1;
            end
         end
         OP_DIV_STORE: begin
            nrm_ff[cmd.comp] <= cr_ff[cmd.comp][CrossW-1] ? -16'($signed({1'b0, quo_clip}))
                                                        : 16'($signed({1'b0, quo_clip}));
         end
         default: ;
      endcase

      case (cmd.cap)
         CAP_CR0:  cr_ff[0]  <= acc_ff[CrossW-1:0];
         CAP_CR1:  cr_ff[1]  <= acc_ff[CrossW-1:0];
         CAP_CR2:  cr_ff[2]  <= acc_ff[CrossW-1:0];
         CAP_POSX: pos_ff[0] <= round_sat24(acc_ff, 26);
         CAP_POSY: pos_ff[1] <= round_sat24(acc_ff, 26);
         CAP_POSZ: pos_ff[2] <= round_sat24(acc_ff, 26);
         CAP_U:    u_ff      <= round_sat24(acc_ff, 16);
         CAP_V:    v_ff      <= round_sat24(acc_ff, 16);
         default: ;
      endcase
   end

   assign status.degenerate = (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
   assign status.mag_high   = (|mag_ff[0][CrossW-1:30]) || (|mag_ff[1][CrossW-1:30]) ||
                              (|mag_ff[2][CrossW-1:30]);
   assign status.mag_low    = !((|mag_ff[0][CrossW-1:29]) || (|mag_ff[1][CrossW-1:29]) ||
                                (|mag_ff[2][CrossW-1:29]));

   // world normal is (x, z, -y) of the map-space normal
   assign norm_z   = -nrm_ff[1];
   assign rsp_data = {v_ff, u_ff, norm_z, nrm_ff[2], nrm_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};

endmodule

/* design/tnus_ctrl.sv */
`timescale 1ns / 1ps
// controller: vertex phase, triangle sequencing and handshake control
// depends on tnus_pkg
module tnus_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_tlast,
   input  tnus_pkg::status_type status,
   output tnus_pkg::cmd_type    cmd
);
   import tnus_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_CROSS  = 10'b0000000010,
      S_NORM   = 10'b0000000100,
      S_SQUARE = 10'b0000001000,
      S_SQRT   = 10'b0000010000,
      S_DIVLD  = 10'b0000100000,
      S_DIV    = 10'b0001000000,
      S_DIVST  = 10'b0010000000,
      S_EMIT   = 10'b0100000000,
      S_OUT    = 10'b1000000000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] comp_ff, comp_in;
   logic [1:0] vsel_ff, vsel_in;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      comp_in  = comp_ff;
      vsel_in  = vsel_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.a_sel = A_ZERO;
      cmd.b_sel = B_ZERO;
      cmd.mac   = MAC_HOLD;
      cmd.cap   = CAP_NONE;
      cmd.vsel  = vsel_ff;
      cmd.comp  = comp_ff;
      cmd.idx   = cnt_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (phase_ff)
                  2'd1: begin
                     cmd.op   = OP_STORE_B;
                     phase_in = 2'd2;
                  end
                  2'd2: begin
                     cmd.op   = OP_STORE_C;
                     phase_in = 2'd0;
                     cnt_in   = '0;
                     state_in = S_CROSS;
                  end
                  default: begin
                     cmd.op   = OP_STORE_A;
                     phase_in = 2'd1;
                  end
               endcase
            end
         end
         S_CROSS: begin
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin cmd.a_sel = A_D1Y; cmd.b_sel = B_D2Z; cmd.mac = MAC_CLR_ADD; end
               5'd1: begin cmd.a_sel = A_D1Z; cmd.b_sel = B_D2Y; cmd.mac = MAC_SUB; end
               5'd2: begin cmd.a_sel = A_D1Z; cmd.b_sel = B_D2X; cmd.mac = MAC_CLR_ADD; end
               5'd3: begin
                  cmd.a_sel = A_D1X; cmd.b_sel = B_D2Z; cmd.mac = MAC_SUB; cmd.cap = CAP_CR0;
               end
               5'd4: begin cmd.a_sel = A_D1X; cmd.b_sel = B_D2Y; cmd.mac = MAC_CLR_ADD; end
               5'd5: begin
                  cmd.a_sel = A_D1Y; cmd.b_sel = B_D2X; cmd.mac = MAC_SUB; cmd.cap = CAP_CR1;
               end
               5'd7: cmd.cap = CAP_CR2;
               5'd8: begin
                  if (status.degenerate) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.op   = OP_MAG_LOAD;
                     state_in = S_NORM;
                  end
               end
               default: ;
            endcase
         end
         S_NORM: begin
            if (status.mag_high) begin
               cmd.op = OP_MAG_RIGHT;
            end else if (status.mag_low) begin
               cmd.op = OP_MAG_LEFT;
            end else begin
               cnt_in   = '0;
               state_in = S_SQUARE;
            end
         end
         S_SQUARE: begin
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin cmd.a_sel = A_MAG0; cmd.b_sel = B_MAG0; cmd.mac = MAC_CLR_ADD; end
               5'd1: begin cmd.a_sel = A_MAG1; cmd.b_sel = B_MAG1; cmd.mac = MAC_ADD; end
               5'd2: begin cmd.a_sel = A_MAG2; cmd.b_sel = B_MAG2; cmd.mac = MAC_ADD; end
               5'd4: begin
                  cmd.op   = OP_SQRT_LOAD;
                  cnt_in   = 5'd31;
                  state_in = S_SQRT;
               end
               default: ;
            endcase
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               comp_in  = '0;
               state_in = S_DIVLD;
            end
         end
         S_DIVLD: begin
            cmd.op   = OP_DIV_LOAD;
            cnt_in   = 5'd14;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) begin
               state_in = S_DIVST;
            end
         end
         S_DIVST: begin
            cmd.op = OP_DIV_STORE;
            if (comp_ff == 2'd2) begin
               vsel_in  = VSEL_A;
               cnt_in   = '0;
               state_in = S_EMIT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_DIVLD;
            end
         end
         S_EMIT: begin
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               5'd0: begin cmd.a_sel = A_VX; cmd.b_sel = B_K; cmd.mac = MAC_CLR_ADD; end
               5'd1: begin cmd.a_sel = A_VZ; cmd.b_sel = B_K; cmd.mac = MAC_CLR_ADD; end
               5'd2: begin
                  cmd.a_sel = A_VNY; cmd.b_sel = B_K; cmd.mac = MAC_CLR_ADD; cmd.cap = CAP_POSX;
               end
               5'd3: begin
                  cmd.a_sel = A_VX; cmd.b_sel = B_UX; cmd.mac = MAC_CLR_ADD; cmd.cap = CAP_POSY;
               end
               5'd4: begin
                  cmd.a_sel = A_VY; cmd.b_sel = B_UY; cmd.mac = MAC_ADD; cmd.cap = CAP_POSZ;
               end
               5'd5: begin cmd.a_sel = A_VZ; cmd.b_sel = B_UZ; cmd.mac = MAC_ADD; end
               5'd6: begin cmd.a_sel = A_UOFF; cmd.b_sel = B_256; cmd.mac = MAC_ADD; end
               5'd7: begin cmd.a_sel = A_VX; cmd.b_sel = B_VX; cmd.mac = MAC_CLR_ADD; end
               5'd8: begin
                  cmd.a_sel = A_VY; cmd.b_sel = B_VY; cmd.mac = MAC_ADD; cmd.cap = CAP_U;
               end
               5'd9: begin cmd.a_sel = A_VZ; cmd.b_sel = B_VZ; cmd.mac = MAC_ADD; end
               5'd10: begin cmd.a_sel = A_VOFF; cmd.b_sel = B_256; cmd.mac = MAC_ADD; end
               5'd12: begin
                  cmd.cap  = CAP_V;
                  state_in = S_OUT;
               end
               default: ;
            endcase
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (vsel_ff == VSEL_B) begin
                  state_in = S_IDLE;
               end else begin
                  vsel_in  = (vsel_ff == VSEL_A) ? VSEL_C : VSEL_B;
                  cnt_in   = '0;
                  state_in = S_EMIT;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         cnt_ff   <= '0;
         comp_ff  <= '0;
         vsel_ff  <= VSEL_A;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         comp_ff  <= comp_in;
         vsel_ff  <= vsel_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = (state_ff == S_OUT) && (vsel_ff == VSEL_B);

endmodule

/* design/triangle_normal_uv_setup.sv */
`timescale 1ns / 1ps
// top level of the triangle normal/uv setup block
// depends on tnus_pkg, tnus_regs, tnus_ctrl, tnus_dp
//
// req_ channel: one map-space vertex per transaction (x, y, z, Q16.8).
// rsp_ channel: three vertices per non-degenerate triangle in the order
//   A, C, B with metre position, shared unit normal and planar u,v;
//   rsp_tlast marks the third.
// csr_ channel: texture vectors and offsets, index 0..7, always ready;
//   write only while the block is idle.
// first and second vertex of a triangle: stored while idle, no output.
// third vertex: setup (cross product, normalise, squares, 32 square root
//   steps, three divides), then per output vertex a run on the shared
//   multiply-accumulate unit plus a hand-over; a degenerate triangle returns
//   to idle after its cross product.
// one triangle is in flight at a time: req_tready is high only when idle.
// if the receiver stalls, the result holds and the block waits.
// reset (synchronous, active high) clears the vertex phase, the
//   sequencer and the configuration registers to their defaults; held
//   vertices and datapath results are not cleared.
module triangle_normal_uv_setup (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [71:0]                  req_tdata,   // in_x, in_y, in_z
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
   output logic [tnus_pkg::RspW-1:0]    rsp_tdata,
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tnus_pkg::IndexW-1:0]  csr_index,
   input  logic [tnus_pkg::CfgW-1:0]    csr_data
);
   import tnus_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tnus_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   tnus_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   tnus_dp u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .cfg      (cfg),
      .in_data  (req_tdata),
      .status   (status),
      .rsp_data (rsp_tdata)
   );

   // never ready for input while a result is offered
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while result pending");

   // last vertex of a triangle returns the block to idle
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block not idle after last vertex");

   // normal components stay within unit range
   a_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[87:72]) <= 16'sd16384 &&
                      $signed(rsp_tdata[87:72]) >= -16'sd16384 &&
                      $signed(rsp_tdata[103:88]) <= 16'sd16384 &&
                      $signed(rsp_tdata[103:88]) >= -16'sd16384 &&
                      $signed(rsp_tdata[119:104]) <= 16'sd16384 &&
                      $signed(rsp_tdata[119:104]) >= -16'sd16384))
      else $error("normal component out of range");

endmodule

/* tb/tb_triangle_normal_uv_setup.sv */
`timescale 1ns / 1ps
// self-checking bench for triangle_normal_uv_setup: a table of directed vertices, then random
// triangles, with the results predicted in the bench and compared field by field
// depends on tnus_pkg and the triangle_normal_uv_setup rtl
module tb_triangle_normal_uv_setup;
   import tnus_pkg::*;

   localparam longint MAX_CYCLES = 400000;
   localparam int SETTLE = 200;

   typedef struct packed {
      logic [23:0] tv;
      logic [23:0] tu;
      logic [15:0] nz;
      logic [15:0] ny;
      logic [15:0] nx;
      logic [23:0] pz;
      logic [23:0] py;
      logic [23:0] px;
   } rsp_fields_t;

   typedef struct {
      rsp_fields_t f;
      logic        last;
   } vertex_out_t;

   typedef struct {
      logic signed [23:0] x, y, z;
      logic               chk;
      rsp_fields_t        f;
   } stim_row_t;

   // unit triangle at the origin: A (0,0,0), B (1,0,0), C (0,1,0)
   localparam rsp_fields_t UNIT_A = '{px: 24'h0, py: 24'h0, pz: 24'h0, nx: 16'h0,
                                      ny: 16'hC000, nz: 16'h0, tu: 24'h0, tv: 24'h0};
   localparam rsp_fields_t UNIT_B = '{px: 24'h00014C, py: 24'h0, pz: 24'h0, nx: 16'h0,
                                      ny: 16'hC000, nz: 16'h0, tu: 24'h001000, tv: 24'h0};
   localparam rsp_fields_t UNIT_C = '{px: 24'h0, py: 24'h0, pz: 24'hFFFEB4, nx: 16'h0,
                                      ny: 16'hC000, nz: 16'h0, tu: 24'h0, tv: 24'h001000};

   logic clock, reset;
   logic req_tvalid, req_tready;
   logic [71:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RspW-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid, csr_ready;
   logic [IndexW-1:0] csr_index;
   logic [CfgW-1:0] csr_data;

   longint tex_reg[8];
   longint held[2][3];
   int     phase;
   vertex_out_t vertex_queue[$];
   int     errors = 0;
   longint cycles = 0;
   bit     hold_off = 0;
   int     rsp_wait = 0;
   stim_row_t table_rows[$];

   triangle_normal_uv_setup i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("triangle_normal_uv_setup: mismatch");
         $finish;
      end
   end

   function automatic longint round_away(longint v, int n);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (longint'(1) << (n - 1))) >>> n;
      return v < 0 ? -m : m;
   endfunction

   function automatic logic [23:0] clamp24(longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return v[23:0];
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic rsp_fields_t vertex_fields(longint p[3], longint n[3]);
      rsp_fields_t f;
      longint u, v;
      u = p[0] * tex_reg[0] + p[1] * tex_reg[1] + p[2] * tex_reg[2] + tex_reg[3] * 256;
      v = p[0] * tex_reg[4] + p[1] * tex_reg[5] + p[2] * tex_reg[6] + tex_reg[7] * 256;
      f.px = clamp24(round_away(p[0] * longint'(SCALE_K), 26));
      f.py = clamp24(round_away(p[2] * longint'(SCALE_K), 26));
      f.pz = clamp24(round_away(-p[1] * longint'(SCALE_K), 26));
      f.nx = n[0][15:0];
      f.ny = n[1][15:0];
      f.nz = n[2][15:0];
      f.tu = clamp24(round_away(u, 16));
      f.tv = clamp24(round_away(v, 16));
      return f;
   endfunction

   // vertex phase, cross product, normalise and emission in A, C, B order
   task automatic predict_vertex(logic signed [23:0] x, y, z);
      longint c[3], d1[3], d2[3], cr[3], nrm[3], wn[3], pa[3], pb[3];
      logic [63:0] mag[3], m, len;
      vertex_out_t o;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      if (phase == 1) begin
         held[1] = c;
         phase = 2;
         return;
      end
      if (phase != 2) begin
         held[0] = c;
         phase = 1;
         return;
      end
      phase = 0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = c[i] - held[0][i];
         d2[i] = held[1][i] - held[0][i];
      end
      cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
      cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
      cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
      if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) return;
      for (int i = 0; i < 3; i++) mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      m = mag[0];
      if (mag[1] > m) m = mag[1];
      if (mag[2] > m) m = mag[2];
      while (m >= (64'd1 << 30)) begin
         m = m >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (m < (64'd1 << 29)) begin
         m = m << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      len = int_sqrt(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      if (len == 0) len = 1;
      for (int i = 0; i < 3; i++) begin
         m = ((mag[i] << 14) + (len >> 1)) / len;
         if (m > 16384) m = 16384;
         nrm[i] = cr[i] < 0 ? -longint'(m) : longint'(m);
      end
      wn[0] = nrm[0];
      wn[1] = nrm[2];
      wn[2] = -nrm[1];
      pa = held[0];
      pb = held[1];
      o.last = 0;
      o.f = vertex_fields(pa, wn);
      vertex_queue.push_back(o);
      o.f = vertex_fields(c, wn);
      vertex_queue.push_back(o);
      o.last = 1;
      o.f = vertex_fields(pb, wn);
      vertex_queue.push_back(o);
   endtask

   task automatic send_vertex(logic signed [23:0] x, y, z);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_vertex(x, y, z);
   endtask

   task automatic write_reg(logic [IndexW-1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx < 8) tex_reg[idx] = longint'($signed(val));
   endtask

   task automatic drain;
      req_tvalid <= 0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic signed [23:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
         1: return 24'($urandom);
         default: return 24'($signed($urandom_range(0, 8191)) - 4096);
      endcase
   endfunction

   // receiver: random idle gaps after each transaction, plus one long hold-off
   always @(posedge clock) begin
      int w;
      w = $urandom_range(0, 3);
      if (reset || hold_off) begin
         rsp_tready <= 0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_tready <= (w == 0);
         rsp_wait   <= w;
      end else if (rsp_wait > 1) begin
         rsp_tready <= 0;
         rsp_wait   <= rsp_wait - 1;
      end else begin
         rsp_tready <= 1;
         rsp_wait   <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (vertex_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected transaction %h", rsp_tdata);
         end else begin
            vertex_out_t e;
            e = vertex_queue.pop_front();
            if (e.f.px !== rsp_tdata[23:0] || e.f.py !== rsp_tdata[47:24]
                || e.f.pz !== rsp_tdata[71:48] || e.f.nx !== rsp_tdata[87:72]
                || e.f.ny !== rsp_tdata[103:88] || e.f.nz !== rsp_tdata[119:104]
                || e.f.tu !== rsp_tdata[143:120] || e.f.tv !== rsp_tdata[167:144]
                || e.last !== rsp_tlast) begin
               errors++;
               if (errors <= 10)
                  $display("exp %h/%b got %h/%b", e.f, e.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin
      logic signed [23:0] ax, ay, az;
      stim_row_t r;
      int n;
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      tex_reg = '{1048576, 0, 0, 0, 0, 1048576, 0, 0};
      phase = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed rows; unit triangle at origin is typed in by hand
      table_rows = '{
         '{0, 0, 0, 1, UNIT_A}, '{256, 0, 0, 1, UNIT_B}, '{0, 256, 0, 1, UNIT_C},
         '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, '0},
         '{24'sh800000, 24'sh800000, 24'sh800000, 0, '0},
         '{24'sh7FFFFF, 24'sh800000, 0, 0, '0},
         // degenerate: collinear
         '{0, 0, 0, 0, '0}, '{256, 256, 256, 0, '0}, '{512, 512, 512, 0, '0},
         // degenerate: repeated point
         '{5, 5, 5, 0, '0}, '{5, 5, 5, 0, '0}, '{7, 1, 3, 0, '0},
         '{24'sh800000, 0, 0, 0, '0}, '{0, 24'sh7FFFFF, 0, 0, '0},
         '{0, 0, 24'sh800000, 0, '0},
         '{-1, -1, -1, 0, '0}, '{1, -1, 1, 0, '0}, '{0, 24'sh7FFFFF, 24'sh800000, 0, '0}
      };
      foreach (table_rows[i]) begin
         r = table_rows[i];
         send_vertex(r.x, r.y, r.z);
         // typed rows stand in for the predicted transactions of their triangle
         if (r.chk && (i % 3 == 2)) begin
            n = vertex_queue.size();
            vertex_queue[n - 3].f = table_rows[i - 2].f;
            vertex_queue[n - 2].f = r.f;
            vertex_queue[n - 1].f = table_rows[i - 1].f;
         end
      end
      drain();

      // extreme texture settings, every register written
      write_reg(CSR_U_VEC_X, 32'h7FFFFFFF);
      write_reg(CSR_U_VEC_Y, 32'h80000000);
      write_reg(CSR_U_VEC_Z, 32'h7FFFFFFF);
      write_reg(CSR_U_OFFSET, 32'h80000000);
      write_reg(CSR_V_VEC_X, 32'h80000000);
      write_reg(CSR_V_VEC_Y, 32'h7FFFFFFF);
      write_reg(CSR_V_VEC_Z, 32'h80000000);
      write_reg(CSR_V_OFFSET, 32'h7FFFFFFF);
      write_reg(4'd12, 32'h12345678);
      csr_valid <= 0;

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         repeat (12) send_vertex(rand_coord(), rand_coord(), rand_coord());
      join
      drain();

      for (int p = 0; p < 3; p++) begin
         for (int i = 0; i < 8; i++)
            write_reg(i[IndexW-1:0], p == 2 ? 32'h0 : $urandom);
         csr_valid <= 0;
         for (int t = 0; t < 33; t++) begin
            ax = rand_coord();
            ay = rand_coord();
            az = rand_coord();
            send_vertex(ax, ay, az);
            if ($urandom_range(0, 9) == 0) begin
               send_vertex(ax, ay, az);
               send_vertex(ax, ay, az);
            end else begin
               send_vertex(ax + 24'($urandom_range(0, 2047)), ay, az + 24'($urandom_range(0, 63)));
               send_vertex(rand_coord(), ay + 24'($urandom_range(0, 2047)), rand_coord());
            end
         end
         drain();
      end

      if (errors == 0 && vertex_queue.size() == 0) begin
         $display("triangle_normal_uv_setup: match");
      end else begin
         $display("triangle_normal_uv_setup: mismatch");
      end
      $finish;
   end
endmodule
